@@ src/dsbr_pkg.sv @@
// dsbr_pkg: shared types and constants for the decaying source brightness row
// holds the request and glyph payload structs, the config register layout and codes
// no dependencies
package dsbr_pkg;

  localparam int ID_W      = 16;
  localparam int FRAME_W   = 32;
  localparam int GLYPH_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  // request operation codes
  localparam logic OP_FLASH = 1'b0;
  localparam logic OP_PAINT = 1'b1;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_THR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_THR   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_THR      = 2'd3;

  // config reset values, Q0.16
  localparam logic [CFG_W-1:0] DECAY_FACTOR_RST = 16'd36045;
  localparam logic [CFG_W-1:0] BRIGHT_THR_RST   = 16'd52429;
  localparam logic [CFG_W-1:0] MEDIUM_THR_RST   = 16'd26214;
  localparam logic [CFG_W-1:0] DIM_THR_RST      = 16'd6554;

  // glyph codes
  localparam logic [GLYPH_W-1:0] GLYPH_BLANK  = 2'd0;
  localparam logic [GLYPH_W-1:0] GLYPH_DIM    = 2'd1;
  localparam logic [GLYPH_W-1:0] GLYPH_MEDIUM = 2'd2;
  localparam logic [GLYPH_W-1:0] GLYPH_BRIGHT = 2'd3;

  typedef struct packed {
    logic            operation;
    logic [ID_W-1:0] source_id;
  } item_t;

  typedef struct packed {
    logic [ID_W-1:0]    row_source;
    logic [GLYPH_W-1:0] glyph_level;
    logic [FRAME_W-1:0] frame_number;
    logic               last_in_row;
  } glyph_t;

  typedef struct packed {
    logic [CFG_W-1:0] decay_factor;
    logic [CFG_W-1:0] bright_threshold;
    logic [CFG_W-1:0] medium_threshold;
    logic [CFG_W-1:0] dim_threshold;
  } cfg_t;

endpackage

@@ src/dsbr_ram.sv @@
// dsbr_ram: source table memory, one write port and one registered read port
// holds {source id, level} per slot, contents undefined until written
// no dependencies
module dsbr_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/dsbr_unit.sv @@
// dsbr_unit: shared per-source arithmetic, decay multiply and glyph classify
// one level in per enabled cycle, registered decayed level and glyph out
// depends on dsbr_pkg
module dsbr_unit #(
  parameter int LEVEL_BITS = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [LEVEL_BITS-1:0]        level,
  input  dsbr_pkg::cfg_t               cfg,
  output logic [LEVEL_BITS-1:0]        decayed,
  output logic [dsbr_pkg::GLYPH_W-1:0] glyph_code
);

  localparam int PW = LEVEL_BITS + dsbr_pkg::CFG_W;

  logic [PW-1:0] level_w;
  logic [PW-1:0] factor_w;
  logic [PW-1:0] product;
  logic [PW-1:0] level_cmp;
  logic [PW-1:0] bright_cmp;
  logic [PW-1:0] medium_cmp;
  logic [PW-1:0] dim_cmp;
  logic [dsbr_pkg::GLYPH_W-1:0] glyph_comb;

  // decay multiply, Q0.LEVEL_BITS times Q0.16
  assign level_w  = PW'(level);
  assign factor_w = PW'(cfg.decay_factor);
  assign product  = level_w * factor_w;

  // align level and thresholds on a common scale
  assign level_cmp  = {level, {dsbr_pkg::CFG_W{1'b0}}};
  assign bright_cmp = {cfg.bright_threshold, {LEVEL_BITS{1'b0}}};
  assign medium_cmp = {cfg.medium_threshold, {LEVEL_BITS{1'b0}}};
  assign dim_cmp    = {cfg.dim_threshold, {LEVEL_BITS{1'b0}}};

  // bright first, then medium, then dim
  always_comb begin
    if (level_cmp > bright_cmp) begin
      glyph_comb = dsbr_pkg::GLYPH_BRIGHT;
    end else if (level_cmp > medium_cmp) begin
      glyph_comb = dsbr_pkg::GLYPH_MEDIUM;
    end else if (level_cmp > dim_cmp) begin
      glyph_comb = dsbr_pkg::GLYPH_DIM;
    end else begin
      glyph_comb = dsbr_pkg::GLYPH_BLANK;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (en) begin
      decayed    <= product[PW-1:dsbr_pkg::CFG_W];
      glyph_code <= glyph_comb;
    end
  end

endmodule

@@ src/decaying_source_brightness_row.sv @@
// decaying_source_brightness_row: sorted source table with decaying brightness
// top level: sequencer, config registers, glyph output register
// depends on dsbr_pkg, dsbr_ram, dsbr_unit
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+---------------------------------
//   request  | item_valid / item_stall     | item  (operation, source_id)
//   glyph    | glyph_valid / glyph_stall   | glyph (row_source, glyph_level,
//            |                             |        frame_number, last_in_row)
//   config   | cfg_we                      | cfg_index, cfg_data
//
// a flash walks the table entries in order (S_FIND_RD, S_FIND_CHK) to find the
// id or the insert point, then shifts each entry above it up a slot (S_SHIFT_RD,
// S_SHIFT_WR) over the single table memory port pair
// a paint tick reads, multiplies and writes back each source in turn,
// and waits while the glyph output stalls
// reset clears the count, frame counter and config; the table is not cleared
// the request side is stalled whenever a request is in progress
module decaying_source_brightness_row #(
  parameter int MAX_SOURCES = 16,
  parameter int LEVEL_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  dsbr_pkg::item_t                item,
  output logic                           glyph_valid,
  input  logic                           glyph_stall,
  output dsbr_pkg::glyph_t               glyph,
  input  logic                           cfg_we,
  input  logic [dsbr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dsbr_pkg::CFG_W-1:0]     cfg_data
);

  localparam int AW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int CW = $clog2(MAX_SOURCES + 1);
  localparam int EW = dsbr_pkg::ID_W + LEVEL_BITS;
  localparam logic [CW-1:0]         MAX_CNT    = CW'(MAX_SOURCES);
  localparam logic [LEVEL_BITS-1:0] FULL_LEVEL = {LEVEL_BITS{1'b1}};

  // sequencer states
  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_FIND_RD   = 3'd1;
  localparam logic [2:0] S_FIND_CHK  = 3'd2;
  localparam logic [2:0] S_SHIFT_RD  = 3'd3;
  localparam logic [2:0] S_SHIFT_WR  = 3'd4;
  localparam logic [2:0] S_PAINT_RD  = 3'd5;
  localparam logic [2:0] S_PAINT_MUL = 3'd6;
  localparam logic [2:0] S_PAINT_OUT = 3'd7;

  logic [2:0]                    state, state_next;
  logic [CW-1:0]                 idx, idx_next;
  logic [CW-1:0]                 pos, pos_next;
  logic [CW-1:0]                 count, count_next;
  logic [dsbr_pkg::FRAME_W-1:0]  frame, frame_next;
  logic [dsbr_pkg::ID_W-1:0]     req_id, req_id_next;
  dsbr_pkg::cfg_t                cfg;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [EW-1:0]                 ram_wdata;
  logic                          ram_re;
  logic [AW-1:0]                 ram_raddr;
  logic [EW-1:0]                 ram_rdata;
  logic [dsbr_pkg::ID_W-1:0]     rd_id;
  logic [LEVEL_BITS-1:0]         rd_level;
  logic [LEVEL_BITS-1:0]         decayed;
  logic [dsbr_pkg::GLYPH_W-1:0]  glyph_code;

  logic                          item_accept;
  logic                          flash_start;
  logic                          paint_start;
  logic                          out_free;
  logic                          load_out;
  logic                          is_last;
  logic                          unit_en;
  logic [CW-1:0]                 idx_inc;
  logic [CW-1:0]                 idx_dec;

  // request handshake
  assign item_stall  = (state != S_IDLE);
  assign item_accept = item_valid && !item_stall;
  assign flash_start = item_accept && (item.operation == dsbr_pkg::OP_FLASH);
  assign paint_start = item_accept && (item.operation == dsbr_pkg::OP_PAINT) &&
                       (count != '0);

  assign out_free = !glyph_valid || !glyph_stall;
  assign idx_inc  = idx + CW'(1);
  assign idx_dec  = idx - CW'(1);
  assign is_last  = (idx_inc == count);
  assign rd_id    = ram_rdata[EW-1:LEVEL_BITS];
  assign rd_level = ram_rdata[LEVEL_BITS-1:0];
  assign unit_en  = (state == S_PAINT_MUL);

  dsbr_ram #(
    .DEPTH (MAX_SOURCES),
    .WIDTH (EW),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dsbr_unit #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_unit (
    .clk        (clk),
    .en         (unit_en),
    .level      (rd_level),
    .cfg        (cfg),
    .decayed    (decayed),
    .glyph_code (glyph_code)
  );

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.decay_factor     <= dsbr_pkg::DECAY_FACTOR_RST;
      cfg.bright_threshold <= dsbr_pkg::BRIGHT_THR_RST;
      cfg.medium_threshold <= dsbr_pkg::MEDIUM_THR_RST;
      cfg.dim_threshold    <= dsbr_pkg::DIM_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dsbr_pkg::REG_DECAY_FACTOR: cfg.decay_factor     <= cfg_data;
        dsbr_pkg::REG_BRIGHT_THR:   cfg.bright_threshold <= cfg_data;
        dsbr_pkg::REG_MEDIUM_THR:   cfg.medium_threshold <= cfg_data;
        dsbr_pkg::REG_DIM_THR:      cfg.dim_threshold    <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer next state and table access
  always_comb begin
    state_next  = state;
    idx_next    = idx;
    pos_next    = pos;
    count_next  = count;
    frame_next  = frame;
    req_id_next = req_id;
    ram_we      = 1'b0;
    ram_waddr   = idx[AW-1:0];
    ram_wdata   = {req_id, FULL_LEVEL};
    ram_re      = 1'b0;
    ram_raddr   = idx[AW-1:0];
    load_out    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (flash_start) begin
          req_id_next = item.source_id;
          idx_next    = '0;
          state_next  = S_FIND_RD;
        end else if (paint_start) begin
          frame_next = frame + dsbr_pkg::FRAME_W'(1);
          idx_next   = '0;
          state_next = S_PAINT_RD;
        end
      end
      // walk the sorted table looking for the id
      S_FIND_RD: begin
        if (idx == count) begin
          pos_next = idx;
          if (count == MAX_CNT) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = count;
            state_next = S_SHIFT_RD;
          end
        end else begin
          ram_re     = 1'b1;
          state_next = S_FIND_CHK;
        end
      end
      S_FIND_CHK: begin
        if (rd_id == req_id) begin
          ram_we     = 1'b1;
          state_next = S_IDLE;
        end else if (rd_id > req_id) begin
          pos_next = idx;
          if (count == MAX_CNT) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = count;
            state_next = S_SHIFT_RD;
          end
        end else begin
          idx_next   = idx_inc;
          state_next = S_FIND_RD;
        end
      end
      // open a slot at the insert point, top entry first
      S_SHIFT_RD: begin
        if (idx == pos) begin
          ram_we     = 1'b1;
          count_next = count + CW'(1);
          state_next = S_IDLE;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = idx_dec[AW-1:0];
          state_next = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        ram_we     = 1'b1;
        ram_wdata  = ram_rdata;
        idx_next   = idx_dec;
        state_next = S_SHIFT_RD;
      end
      // paint: read, classify and decay, emit and write back
      S_PAINT_RD: begin
        ram_re     = 1'b1;
        state_next = S_PAINT_MUL;
      end
      S_PAINT_MUL: begin
        state_next = S_PAINT_OUT;
      end
      S_PAINT_OUT: begin
        if (out_free) begin
          load_out  = 1'b1;
          ram_we    = 1'b1;
          ram_wdata = {rd_id, decayed};
          if (is_last) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = idx_inc;
            state_next = S_PAINT_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      frame <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      frame <= frame_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    idx    <= idx_next;
    pos    <= pos_next;
    req_id <= req_id_next;
  end

  // glyph output register
  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_valid <= 1'b0;
    end else if (load_out) begin
      glyph_valid <= 1'b1;
    end else if (!glyph_stall) begin
      glyph_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      glyph.row_source   <= rd_id;
      glyph.glyph_level  <= glyph_code;
      glyph.frame_number <= frame;
      glyph.last_in_row  <= is_last;
    end
  end

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_CNT)
    else $error("source count above table size");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(count)) |->
      (count == $past(count) + CW'(1)) && ($past(state) == S_SHIFT_RD))
    else $error("source count changed outside an insert");

  a_frame_on_paint: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(frame)) |-> $past(paint_start))
    else $error("frame counter moved without a non-empty paint");

  a_glyph_from_paint: assert property (@(posedge clk) disable iff (rst)
    $rose(glyph_valid) |-> ($past(state) == S_PAINT_OUT))
    else $error("glyph raised outside the paint walk");

  a_last_ends_paint: assert property (@(posedge clk) disable iff (rst)
    (load_out && is_last) |=> (state == S_IDLE))
    else $error("paint walk did not end on the last glyph");
`endif

endmodule

@@ tb/decaying_source_brightness_row_tb.sv @@
`timescale 1ns / 1ps
// decaying_source_brightness_row_tb: self-checking bench for the source brightness row
// mirrors the sorted source table, levels and frame count to predict every glyph
// depends on dsbr_pkg and decaying_source_brightness_row
module decaying_source_brightness_row_tb;

  localparam int          TABLE_DEPTH    = 16;
  localparam logic [15:0] FULL_SCALE     = 16'hFFFF;
  localparam int          SETTLE_CYCLES  = 100;
  localparam int          DRAIN_LIMIT    = 50000;
  localparam int          RANDOM_PHASES  = 5;
  localparam int          PHASE_REQUESTS = 80;
  localparam int          STEADY_PHASE   = 2;
  localparam int          ID_BITS        = dsbr_pkg::ID_W;
  localparam int          CFG_BITS       = dsbr_pkg::CFG_W;

  // table mirror plus queue of glyphs still owed by the block
  class glyph_row_tracker;
    dsbr_pkg::cfg_t               regs;
    logic [dsbr_pkg::ID_W-1:0]    ids [TABLE_DEPTH];
    logic [15:0]                  levels [TABLE_DEPTH];
    int                           count;
    logic [dsbr_pkg::FRAME_W-1:0] frame;
    dsbr_pkg::glyph_t             pending_glyphs [$];
    int                           errors;

    function new();
      regs   = '{dsbr_pkg::DECAY_FACTOR_RST, dsbr_pkg::BRIGHT_THR_RST,
                 dsbr_pkg::MEDIUM_THR_RST, dsbr_pkg::DIM_THR_RST};
      count  = 0;
      frame  = '0;
      errors = 0;
    endfunction

    // levels and thresholds share the same 16-bit scale, so a plain compare;
    // bright is tested first whatever the threshold order
    function logic [dsbr_pkg::GLYPH_W-1:0] glyph_for(logic [15:0] lvl);
      if (lvl > regs.bright_threshold) return dsbr_pkg::GLYPH_BRIGHT;
      if (lvl > regs.medium_threshold) return dsbr_pkg::GLYPH_MEDIUM;
      if (lvl > regs.dim_threshold) return dsbr_pkg::GLYPH_DIM;
      return dsbr_pkg::GLYPH_BLANK;
    endfunction

    // apply one accepted request to the mirror
    function void note_request(dsbr_pkg::item_t req);
      int               pos;
      int               k;
      dsbr_pkg::glyph_t g;
      logic [31:0]      product;
      if (req.operation == dsbr_pkg::OP_FLASH) begin
        pos = 0;
        while (pos < count && ids[pos] < req.source_id) pos++;
        if (pos < count && ids[pos] == req.source_id) begin
          levels[pos] = FULL_SCALE;
        end else if (count < TABLE_DEPTH) begin
          // open a slot in id order; a full table drops the new source
          for (k = count; k > pos; k--) begin
            ids[k]    = ids[k-1];
            levels[k] = levels[k-1];
          end
          ids[pos]    = req.source_id;
          levels[pos] = FULL_SCALE;
          count++;
        end
      end else if (count > 0) begin
        // paint: glyph judged on the level before decay
        frame++;
        for (k = 0; k < count; k++) begin
          g.row_source   = ids[k];
          g.glyph_level  = glyph_for(levels[k]);
          g.frame_number = frame;
          g.last_in_row  = (k == count - 1);
          pending_glyphs.push_back(g);
          product   = levels[k] * regs.decay_factor;
          levels[k] = product[31:16];
        end
      end
    endfunction

    function void report(string field, longint want, longint got);
      $display("%0t glyph %s mismatch: expected %0h actual %0h", $time, field, want, got);
      errors++;
    endfunction

    // compare one accepted glyph with the oldest owed one
    function void check_glyph(dsbr_pkg::glyph_t got);
      dsbr_pkg::glyph_t want;
      if (pending_glyphs.size() == 0) begin
        $display("%0t unexpected glyph: expected none actual source %0h level %0d frame %0d",
                 $time, got.row_source, got.glyph_level, got.frame_number);
        errors++;
        return;
      end
      want = pending_glyphs.pop_front();
      if (got.row_source !== want.row_source)
        report("row_source", longint'(want.row_source), longint'(got.row_source));
      if (got.glyph_level !== want.glyph_level)
        report("glyph_level", longint'(want.glyph_level), longint'(got.glyph_level));
      if (got.frame_number !== want.frame_number)
        report("frame_number", longint'(want.frame_number), longint'(got.frame_number));
      if (got.last_in_row !== want.last_in_row)
        report("last_in_row", longint'(want.last_in_row), longint'(got.last_in_row));
    endfunction
  endclass

  logic                           clk         = 1'b0;
  logic                           rst         = 1'b1;
  logic                           item_valid  = 1'b0;
  logic                           item_stall;
  dsbr_pkg::item_t                item        = '0;
  logic                           glyph_valid;
  logic                           glyph_stall = 1'b0;
  dsbr_pkg::glyph_t               glyph;
  logic                           cfg_we      = 1'b0;
  logic [dsbr_pkg::CFG_IDX_W-1:0] cfg_index   = '0;
  logic [dsbr_pkg::CFG_W-1:0]     cfg_data    = '0;
  bit                             steady      = 1'b0;

  glyph_row_tracker rows = new();

  decaying_source_brightness_row dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .glyph_valid(glyph_valid),
    .glyph_stall(glyph_stall),
    .glyph      (glyph),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // overall time limit
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // random back-pressure on the glyph side
  always @(posedge clk) begin
    glyph_stall <= !steady && ($urandom_range(99) < 33);
  end

  // glyph monitor
  always @(posedge clk) begin
    if (!rst && glyph_valid && !glyph_stall) rows.check_glyph(glyph);
  end

  // present one request, with random idle cycles ahead of it
  task automatic send_request(input logic op, input logic [dsbr_pkg::ID_W-1:0] id);
    dsbr_pkg::item_t req;
    req.operation = op;
    req.source_id = id;
    while (!steady && $urandom_range(99) < 33) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= req;
    do @(posedge clk); while (item_stall);
    rows.note_request(req);
  endtask

  // wait for owed glyphs, then cover a flash still walking the table
  task automatic settle();
    int waited;
    item_valid <= 1'b0;
    waited = 0;
    while (rows.pending_glyphs.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all four registers in turn
  task automatic write_settings(input dsbr_pkg::cfg_t s);
    cfg_we    <= 1'b1;
    cfg_index <= dsbr_pkg::REG_DECAY_FACTOR;
    cfg_data  <= s.decay_factor;
    @(posedge clk);
    cfg_index <= dsbr_pkg::REG_BRIGHT_THR;
    cfg_data  <= s.bright_threshold;
    @(posedge clk);
    cfg_index <= dsbr_pkg::REG_MEDIUM_THR;
    cfg_data  <= s.medium_threshold;
    @(posedge clk);
    cfg_index <= dsbr_pkg::REG_DIM_THR;
    cfg_data  <= s.dim_threshold;
    @(posedge clk);
    cfg_we    <= 1'b0;
    rows.regs = s;
  endtask

  initial begin
    dsbr_pkg::cfg_t            phase_cfg [RANDOM_PHASES];
    logic [dsbr_pkg::ID_W-1:0] id;
    int                        k;
    int                        p;

    // register settings per phase: extremes, inverted thresholds, random, reset values
    phase_cfg[0] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    phase_cfg[1] = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
    phase_cfg[2] = '{16'h8000, 16'd1000, 16'd40000, 16'd50000};
    phase_cfg[3].decay_factor     = CFG_BITS'($urandom_range(65535));
    phase_cfg[3].bright_threshold = CFG_BITS'($urandom_range(65535));
    phase_cfg[3].medium_threshold = CFG_BITS'($urandom_range(65535));
    phase_cfg[3].dim_threshold    = CFG_BITS'($urandom_range(65535));
    phase_cfg[4] = '{dsbr_pkg::DECAY_FACTOR_RST, dsbr_pkg::BRIGHT_THR_RST,
                     dsbr_pkg::MEDIUM_THR_RST, dsbr_pkg::DIM_THR_RST};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: empty paint, single source decay, extreme ids, refresh
    send_request(dsbr_pkg::OP_PAINT, 16'h0000);
    send_request(dsbr_pkg::OP_FLASH, 16'h1234);
    send_request(dsbr_pkg::OP_PAINT, 16'hFFFF);
    send_request(dsbr_pkg::OP_PAINT, 16'h0000);
    send_request(dsbr_pkg::OP_FLASH, 16'hFFFF);
    send_request(dsbr_pkg::OP_FLASH, 16'h0000);
    send_request(dsbr_pkg::OP_FLASH, 16'h1234);
    repeat (4) send_request(dsbr_pkg::OP_PAINT, 16'h5A5A);
    // fill the table, then a new source is dropped and a known one refreshed
    send_request(dsbr_pkg::OP_FLASH, 16'h8000);
    for (k = 1; k <= 12; k++) send_request(dsbr_pkg::OP_FLASH, ID_BITS'(16'h1111 * k));
    send_request(dsbr_pkg::OP_FLASH, 16'h4321);
    send_request(dsbr_pkg::OP_FLASH, 16'hFFFF);
    send_request(dsbr_pkg::OP_PAINT, 16'h0000);
    settle();

    // random phases, one register setting each, one phase with no idling
    for (p = 0; p < RANDOM_PHASES; p++) begin
      write_settings(phase_cfg[p]);
      steady = (p == STEADY_PHASE);
      repeat (PHASE_REQUESTS) begin
        if ($urandom_range(99) < 40) begin
          send_request(dsbr_pkg::OP_PAINT, ID_BITS'($urandom_range(65535)));
        end else begin
          if (rows.count > 0 && $urandom_range(99) < 75)
            id = rows.ids[$urandom_range(rows.count - 1)];
          else
            id = ID_BITS'($urandom_range(65535));
          send_request(dsbr_pkg::OP_FLASH, id);
        end
      end
      settle();
    end

    if (rows.pending_glyphs.size() != 0) begin
      $display("%0t missing glyphs: expected %0d more actual 0", $time,
               rows.pending_glyphs.size());
      rows.errors++;
    end
    if (rows.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/dsbr_pkg.sv
src/dsbr_ram.sv
src/dsbr_unit.sv
src/decaying_source_brightness_row.sv
tb/decaying_source_brightness_row_tb.sv
